FILE: rtl/scfm_pkg.sv
// Shared types, constants and helpers for the sensor channel fault monitor.
package scfm_pkg;

	localparam int CHANNELS    = 3;
	localparam int SAMPLE_BITS = 16;
	localparam int LIMIT_BITS  = 15;
	localparam int COUNT_BITS  = 8;
	localparam int STATUS_BITS = 12;
	localparam int LSTAT_BITS  = 7;
	localparam int CFG_IDX_BITS = 4;

	localparam logic [1:0] MODE_OTHER = 2'd0;
	localparam logic [1:0] MODE_11    = 2'd1;
	localparam logic [1:0] MODE_33    = 2'd2;
	localparam logic [1:0] MODE_44    = 2'd3;

	localparam logic [CFG_IDX_BITS-1:0] CFG_ABS_LIMIT  = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RATE_LIMIT = 4'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PKT_LIMIT  = 4'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CHAN_LIMIT = 4'd3;

	localparam logic [LIMIT_BITS-1:0] ABS_LIMIT_RST  = 15'd2560;
	localparam logic [LIMIT_BITS-1:0] RATE_LIMIT_RST = 15'd200;
	localparam logic [COUNT_BITS-1:0] PKT_LIMIT_RST  = 8'd20;
	localparam logic [COUNT_BITS-1:0] CHAN_LIMIT_RST = 8'd10;

	localparam logic [COUNT_BITS-1:0]  COUNT_MAX         = '1;
	localparam logic [STATUS_BITS-1:0] PACKET_LATCH_BITS = 12'h0DE0;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		logic pkt_fail;
		logic checking;
		logic mode33;
		logic advance;
	} ctl_t;

	typedef struct packed {
		logic [LIMIT_BITS-1:0] abs_limit;
		logic [LIMIT_BITS-1:0] rate_limit;
		logic [COUNT_BITS-1:0] chan_limit;
	} lim_t;

	function automatic logic [STATUS_BITS-1:0] chan_fail_bit(input int idx);
		logic [STATUS_BITS-1:0] bits;
		case (idx)
			0:       bits = 12'h100;
			1:       bits = 12'h400;
			2:       bits = 12'h800;
			default: bits = '0;
		endcase
		return bits;
	endfunction

endpackage

FILE: rtl/scfm_packet.sv
// Packet validity check and packet persistence counter.
module scfm_packet (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  logic                               timeout,
	input  logic                               header_ok,
	input  logic                               checksum_ok,
	input  logic                               payload_ok,
	input  logic [1:0]                         mode,
	input  logic [scfm_pkg::COUNT_BITS-1:0]    pkt_limit,
	output scfm_pkg::ctl_t                     ctl,
	output logic                               pkt_latch
);

	logic [scfm_pkg::COUNT_BITS-1:0] cnt_q, cnt_inc, cnt_nxt;
	logic bad, checking;

	always_comb begin
		checking = (mode == scfm_pkg::MODE_11) || (mode == scfm_pkg::MODE_44);
		bad = timeout || !header_ok || !checksum_ok || !payload_ok;
		ctl.pkt_fail = bad && checking;
		ctl.checking = checking;
		ctl.mode33   = (mode == scfm_pkg::MODE_33);
		ctl.advance  = advance;
		cnt_inc = (cnt_q == scfm_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		pkt_latch = ctl.pkt_fail && (cnt_inc >= pkt_limit);
		// clear on a good packet only while below the persistence count
		if (ctl.pkt_fail) begin
			cnt_nxt = cnt_inc;
		end else if (cnt_q < pkt_limit) begin
			cnt_nxt = '0;
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= cnt_nxt;
		end
	end

endmodule

FILE: rtl/scfm_chan.sv
// One sensor channel: rate and absolute checks, substitution and failure count.
module scfm_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  scfm_pkg::ctl_t        ctl,
	input  scfm_pkg::lim_t        lim,
	input  logic                  hold_flag,
	input  scfm_pkg::sample_t     sample,
	output scfm_pkg::sample_t     value,
	output logic                  abs_bit,
	output logic                  rate_bit,
	output logic                  latch,
	output logic                  subst
);

	scfm_pkg::sample_t held_q, val_in;
	logic [scfm_pkg::COUNT_BITS-1:0] cnt_q, cnt_inc, cnt_nxt;
	logic abs_q, abs_nxt;
	logic signed [scfm_pkg::SAMPLE_BITS:0] diff, val_x, alim_x;
	logic [scfm_pkg::SAMPLE_BITS:0] mag;
	logic oor;

	always_comb begin
		val_in = ctl.pkt_fail ? held_q : sample;
		val_x  = {val_in[scfm_pkg::SAMPLE_BITS-1], val_in};
		diff   = val_x - {held_q[scfm_pkg::SAMPLE_BITS-1], held_q};
		mag    = diff[scfm_pkg::SAMPLE_BITS] ? unsigned'(-diff) : unsigned'(diff);
		rate_bit = mag > {2'b00, lim.rate_limit};

		alim_x = signed'({2'b00, lim.abs_limit});
		oor = (val_x > alim_x) || (val_x < -alim_x);
		abs_bit = oor && (ctl.checking || ctl.mode33);
		// during switchover the flag keeps its value on a failure
		if (abs_bit) begin
			abs_nxt = hold_flag ? abs_q : 1'b1;
		end else begin
			abs_nxt = 1'b0;
		end

		subst = abs_nxt && ((!ctl.pkt_fail && ctl.checking) || ctl.mode33);
		cnt_inc = (cnt_q == scfm_pkg::COUNT_MAX) ? cnt_q : cnt_q + 1'b1;
		value = subst ? held_q : val_in;
		latch = subst && (cnt_inc >= lim.chan_limit);
		if (subst) begin
			cnt_nxt = cnt_inc;
		end else if (cnt_q < lim.chan_limit) begin
			cnt_nxt = '0;
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			cnt_q  <= '0;
			abs_q  <= 1'b0;
		end else if (ctl.advance) begin
			held_q <= value;
			cnt_q  <= cnt_nxt;
			abs_q  <= abs_nxt;
		end
	end

endmodule

FILE: rtl/sensor_channel_fault_monitor_core.sv
// Sensor channel fault monitor: top level with input stage, result stage and config.
// Usage:
//   Input channel: in_valid / in_stall with the packet flags, mode, switchover
//   and three signed Q3.12 samples. Output channel: out_valid / out_stall with
//   the three substituted values, limit status, latched fail status, packet
//   failed and the sticky substitution flag. One result item per input item.
//   Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   abs_limit, rate_limit, packet_fail_limit or channel_fail_limit; other
//   indexes are ignored. Write config only while the block is idle.
//   An accepted item passes from the input register to the result register,
//   where out_valid rises; a stall on the output holds it in the input register.
//   Throughput: one item per cycle while out_stall is low; the checks for a
//   packet are combinational between the input register and the result register,
//   against per-channel held values that the previous item wrote at the same edge.
//   Reset clears held values, counters, latched status, sticky flag and both
//   stage valids, and loads the default limits.
//   A stall on the output holds the result; the input register then fills and
//   in_stall rises in the same cycle, so no item is dropped.
module sensor_channel_fault_monitor_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  timeout,
	input  logic                                  header_ok,
	input  logic                                  checksum_ok,
	input  logic                                  payload_ok,
	input  logic [1:0]                            mode,
	input  logic                                  switchover,
	input  logic signed [scfm_pkg::SAMPLE_BITS-1:0] sample_a,
	input  logic signed [scfm_pkg::SAMPLE_BITS-1:0] sample_b,
	input  logic signed [scfm_pkg::SAMPLE_BITS-1:0] sample_c,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [scfm_pkg::SAMPLE_BITS-1:0] value_a,
	output logic signed [scfm_pkg::SAMPLE_BITS-1:0] value_b,
	output logic signed [scfm_pkg::SAMPLE_BITS-1:0] value_c,
	output logic [scfm_pkg::LSTAT_BITS-1:0]       limit_status,
	output logic [scfm_pkg::STATUS_BITS-1:0]      fail_status,
	output logic                                  packet_failed,
	output logic                                  substituted,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [scfm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [scfm_pkg::LIMIT_BITS-1:0]       cfg_data
);

	localparam int N = scfm_pkg::CHANNELS;

	// config registers
	logic [scfm_pkg::LIMIT_BITS-1:0] abs_limit_q, rate_limit_q;
	logic [scfm_pkg::COUNT_BITS-1:0] pkt_limit_q, chan_limit_q;
	scfm_pkg::lim_t lim;

	// input stage
	logic valid_s1;
	logic timeout_s1, header_ok_s1, checksum_ok_s1, payload_ok_s1, switchover_s1;
	logic [1:0] mode_s1;
	scfm_pkg::sample_t smp_s1 [N];

	// result stage
	logic valid_s2;
	scfm_pkg::sample_t val_s2 [N];
	logic [scfm_pkg::LSTAT_BITS-1:0]  lstat_s2;
	logic [scfm_pkg::STATUS_BITS-1:0] fstat_s2;
	logic pfail_s2, subst_s2;

	// state
	logic [scfm_pkg::STATUS_BITS-1:0] latched_q, latched_nxt;
	logic sticky_q, sticky_nxt;

	logic advance, pkt_latch;
	scfm_pkg::ctl_t ctl;
	scfm_pkg::sample_t val_w [N];
	logic [N-1:0] abs_w, rate_w, latch_w, subst_w;
	logic [scfm_pkg::LSTAT_BITS-1:0] lstat_w;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_comb begin
		lim.abs_limit  = abs_limit_q;
		lim.rate_limit = rate_limit_q;
		lim.chan_limit = chan_limit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			abs_limit_q  <= scfm_pkg::ABS_LIMIT_RST;
			rate_limit_q <= scfm_pkg::RATE_LIMIT_RST;
			pkt_limit_q  <= scfm_pkg::PKT_LIMIT_RST;
			chan_limit_q <= scfm_pkg::CHAN_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				scfm_pkg::CFG_ABS_LIMIT:  abs_limit_q  <= cfg_data;
				scfm_pkg::CFG_RATE_LIMIT: rate_limit_q <= cfg_data;
				scfm_pkg::CFG_PKT_LIMIT:  pkt_limit_q  <= cfg_data[scfm_pkg::COUNT_BITS-1:0];
				scfm_pkg::CFG_CHAN_LIMIT: chan_limit_q <= cfg_data[scfm_pkg::COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			timeout_s1     <= timeout;
			header_ok_s1   <= header_ok;
			checksum_ok_s1 <= checksum_ok;
			payload_ok_s1  <= payload_ok;
			mode_s1        <= mode;
			switchover_s1  <= switchover;
			smp_s1[0]      <= sample_a;
			smp_s1[1]      <= sample_b;
			smp_s1[2]      <= sample_c;
		end
	end

	scfm_packet u_packet (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.timeout     (timeout_s1),
		.header_ok   (header_ok_s1),
		.checksum_ok (checksum_ok_s1),
		.payload_ok  (payload_ok_s1),
		.mode        (mode_s1),
		.pkt_limit   (pkt_limit_q),
		.ctl         (ctl),
		.pkt_latch   (pkt_latch)
	);

	for (genvar g = 0; g < N; g++) begin : g_chan
		scfm_chan u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.lim       (lim),
			.hold_flag ((g == 0) ? switchover_s1 : 1'b0),
			.sample    (smp_s1[g]),
			.value     (val_w[g]),
			.abs_bit   (abs_w[g]),
			.rate_bit  (rate_w[g]),
			.latch     (latch_w[g]),
			.subst     (subst_w[g])
		);
	end

	always_comb begin
		latched_nxt = latched_q;
		if (pkt_latch) begin
			latched_nxt = latched_nxt | scfm_pkg::PACKET_LATCH_BITS;
		end
		lstat_w = '0;
		for (int i = 0; i < N; i++) begin
			if (latch_w[i]) begin
				latched_nxt = latched_nxt | scfm_pkg::chan_fail_bit(i);
			end
			lstat_w[i]     = abs_w[i];
			lstat_w[i + 4] = rate_w[i];
		end
		sticky_nxt = sticky_q || ctl.pkt_fail || (|subst_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q <= '0;
			sticky_q  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			if (advance) begin
				latched_q <= latched_nxt;
				sticky_q  <= sticky_nxt;
			end
			// hold the result while the receiver stalls
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < N; i++) begin
				val_s2[i] <= val_w[i];
			end
			lstat_s2 <= lstat_w;
			fstat_s2 <= latched_nxt;
			pfail_s2 <= ctl.pkt_fail;
			subst_s2 <= sticky_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign value_a       = val_s2[0];
	assign value_b       = val_s2[1];
	assign value_c       = val_s2[2];
	assign limit_status  = lstat_s2;
	assign fail_status   = fstat_s2;
	assign packet_failed = pfail_s2;
	assign substituted   = subst_s2;

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the sensor channel fault monitor core.
module tb;

	localparam int SAMPLE_MAX  = 32767;
	localparam int SAMPLE_MIN  = -32768;
	localparam int HOLD_CYCLES = 150;
	localparam int RUN_ITEMS   = 240;
	localparam int SAT_RUN     = 262;
	localparam int PHASES      = 7;
	localparam int SAT_PHASE   = 6;

	localparam logic [3:0] FLAG_NONE     = 4'b0000;
	localparam logic [3:0] FLAG_TIMEOUT  = 4'b0001;
	localparam logic [3:0] FLAG_HEADER   = 4'b0010;
	localparam logic [3:0] FLAG_CHECKSUM = 4'b0100;
	localparam logic [3:0] FLAG_PAYLOAD  = 4'b1000;
	localparam logic [3:0] FLAG_ALL      = 4'b1111;

	localparam logic [scfm_pkg::CHANNELS-1:0][scfm_pkg::STATUS_BITS-1:0] CHAN_FAIL_MASK =
		{12'h800, 12'h400, 12'h100};

	typedef struct packed {
		logic              timeout;
		logic              header_ok;
		logic              checksum_ok;
		logic              payload_ok;
		logic [1:0]        mode;
		logic              switchover;
		scfm_pkg::sample_t sample_a;
		scfm_pkg::sample_t sample_b;
		scfm_pkg::sample_t sample_c;
	} packet_t;

	typedef struct packed {
		scfm_pkg::sample_t                va;
		scfm_pkg::sample_t                vb;
		scfm_pkg::sample_t                vc;
		logic [scfm_pkg::LSTAT_BITS-1:0]  lstat;
		logic [scfm_pkg::STATUS_BITS-1:0] fstat;
		logic                             pfail;
		logic                             subst;
	} screened_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic timeout = 1'b0;
	logic header_ok = 1'b1;
	logic checksum_ok = 1'b1;
	logic payload_ok = 1'b1;
	logic [1:0] mode = scfm_pkg::MODE_OTHER;
	logic switchover = 1'b0;
	scfm_pkg::sample_t sample_a = '0;
	scfm_pkg::sample_t sample_b = '0;
	scfm_pkg::sample_t sample_c = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	scfm_pkg::sample_t value_a;
	scfm_pkg::sample_t value_b;
	scfm_pkg::sample_t value_c;
	logic [scfm_pkg::LSTAT_BITS-1:0] limit_status;
	logic [scfm_pkg::STATUS_BITS-1:0] fail_status;
	logic packet_failed;
	logic substituted;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [scfm_pkg::CFG_IDX_BITS-1:0] cfg_index = scfm_pkg::CFG_ABS_LIMIT;
	logic [scfm_pkg::LIMIT_BITS-1:0] cfg_data = '0;

	sensor_channel_fault_monitor_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.timeout(timeout),
		.header_ok(header_ok),
		.checksum_ok(checksum_ok),
		.payload_ok(payload_ok),
		.mode(mode),
		.switchover(switchover),
		.sample_a(sample_a),
		.sample_b(sample_b),
		.sample_c(sample_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.value_a(value_a),
		.value_b(value_b),
		.value_c(value_c),
		.limit_status(limit_status),
		.fail_status(fail_status),
		.packet_failed(packet_failed),
		.substituted(substituted),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// monitor shadow: limits and per-channel state
	int cfg_abs = scfm_pkg::ABS_LIMIT_RST;
	int cfg_rate = scfm_pkg::RATE_LIMIT_RST;
	int cfg_pkt_limit = scfm_pkg::PKT_LIMIT_RST;
	int cfg_chan_limit = scfm_pkg::CHAN_LIMIT_RST;
	int held [scfm_pkg::CHANNELS];
	int chan_cnt [scfm_pkg::CHANNELS];
	logic abs_flag [scfm_pkg::CHANNELS];
	int pkt_cnt = 0;
	logic [scfm_pkg::STATUS_BITS-1:0] latched = '0;
	logic sticky = 1'b0;

	packet_t packet_q[$];
	screened_t screened_q[$];
	packet_t drv_pkt;
	packet_t mon_pkt;
	screened_t want;
	int offered_cnt = 0;
	int taken_cnt = 0;
	int result_cnt = 0;
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	// stimulus generator state
	logic [1:0] gen_mode = scfm_pkg::MODE_11;
	int bad_left = 0;
	int oor_left [scfm_pkg::CHANNELS];
	int walk [scfm_pkg::CHANNELS];

	initial begin
		for (int i = 0; i < scfm_pkg::CHANNELS; i++) begin
			held[i] = 0;
			chan_cnt[i] = 0;
			abs_flag[i] = 1'b0;
			oor_left[i] = 0;
			walk[i] = 0;
		end
	end

	function automatic screened_t screen_packet(input packet_t p);
		int v [scfm_pkg::CHANNELS];
		int d;
		logic bad, pfail, chk, m33, oor;
		logic [scfm_pkg::LSTAT_BITS-1:0] lb;
		screened_t r;
		chk = (p.mode == scfm_pkg::MODE_11) || (p.mode == scfm_pkg::MODE_44);
		m33 = (p.mode == scfm_pkg::MODE_33);
		v[0] = p.sample_a;
		v[1] = p.sample_b;
		v[2] = p.sample_c;
		bad = p.timeout || !p.header_ok || !p.checksum_ok || !p.payload_ok;
		pfail = bad && chk;
		lb = '0;
		if (pfail) begin
			for (int i = 0; i < scfm_pkg::CHANNELS; i++)
				v[i] = held[i];
			if (pkt_cnt < scfm_pkg::COUNT_MAX)
				pkt_cnt++;
			sticky = 1'b1;
			if (pkt_cnt >= cfg_pkt_limit)
				latched |= scfm_pkg::PACKET_LATCH_BITS;
		end else if (pkt_cnt < cfg_pkt_limit) begin
			pkt_cnt = 0;
		end
		for (int i = 0; i < scfm_pkg::CHANNELS; i++) begin
			d = v[i] - held[i];
			if (d < 0)
				d = -d;
			if (d > cfg_rate)
				lb[i + 4] = 1'b1;
			oor = (v[i] > cfg_abs) || (v[i] < -cfg_abs);
			if (oor && (chk || m33)) begin
				lb[i] = 1'b1;
				// switchover freezes the channel 0 flag on a failure
				if (i != 0 || !p.switchover)
					abs_flag[i] = 1'b1;
			end else begin
				abs_flag[i] = 1'b0;
			end
			if (abs_flag[i] && ((!pfail && chk) || m33)) begin
				sticky = 1'b1;
				v[i] = held[i];
				if (chan_cnt[i] < scfm_pkg::COUNT_MAX)
					chan_cnt[i]++;
				if (chan_cnt[i] >= cfg_chan_limit)
					latched |= CHAN_FAIL_MASK[i];
			end else begin
				held[i] = v[i];
				if (chan_cnt[i] < cfg_chan_limit)
					chan_cnt[i] = 0;
			end
		end
		r.va = scfm_pkg::sample_t'(v[0]);
		r.vb = scfm_pkg::sample_t'(v[1]);
		r.vc = scfm_pkg::sample_t'(v[2]);
		r.lstat = lb;
		r.fstat = latched;
		r.pfail = pfail;
		r.subst = sticky;
		return r;
	endfunction

	function automatic packet_t make_packet(input logic [3:0] flags, input logic [1:0] md,
			input logic sw, input int a, input int b, input int c);
		packet_t p;
		p.timeout = flags[0];
		p.header_ok = !flags[1];
		p.checksum_ok = !flags[2];
		p.payload_ok = !flags[3];
		p.mode = md;
		p.switchover = sw;
		p.sample_a = scfm_pkg::sample_t'(a);
		p.sample_b = scfm_pkg::sample_t'(b);
		p.sample_c = scfm_pkg::sample_t'(c);
		return p;
	endfunction

	function automatic int burst_cap(input int lim);
		return (lim < 38) ? lim + 2 : 40;
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return scfm_pkg::MODE_11;
		else if (r < 80)
			return scfm_pkg::MODE_44;
		else if (r < 90)
			return scfm_pkg::MODE_33;
		return scfm_pkg::MODE_OTHER;
	endfunction

	function automatic int pick_sample(input int ch);
		int r, s, span;
		r = $urandom_range(99);
		span = cfg_rate + cfg_rate / 4 + 1;
		if (oor_left[ch] > 0 || r < 3) begin
			if (oor_left[ch] > 0)
				oor_left[ch]--;
			else
				oor_left[ch] = $urandom_range(0, burst_cap(cfg_chan_limit));
			s = cfg_abs + int'($urandom_range(1, 300));
			if ($urandom_range(1))
				s = -s;
		end else if (r < 65) begin
			// walk around the last in-range sample, straddling the rate limit
			s = walk[ch] + int'($urandom_range(0, 2 * span)) - span;
		end else if (r < 80) begin
			s = cfg_abs + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(1))
				s = -s;
		end else if (r < 93) begin
			s = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
		end else begin
			s = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
		end
		if (s > SAMPLE_MAX)
			s = SAMPLE_MAX;
		if (s < SAMPLE_MIN)
			s = SAMPLE_MIN;
		if (s <= cfg_abs && s >= -cfg_abs)
			walk[ch] = s;
		return s;
	endfunction

	function automatic packet_t gen_packet();
		logic [3:0] flags;
		int r;
		if ($urandom_range(99) < 6)
			gen_mode = pick_mode();
		flags = FLAG_NONE;
		if (bad_left > 0) begin
			bad_left--;
			flags = 4'($urandom_range(1, 15));
		end else begin
			r = $urandom_range(99);
			if (r < 4)
				bad_left = $urandom_range(1, burst_cap(cfg_pkt_limit));
			else if (r < 7)
				flags = 4'($urandom_range(1, 15));
		end
		return make_packet(flags, gen_mode, $urandom_range(99) < 15,
			pick_sample(0), pick_sample(1), pick_sample(2));
	endfunction

	task automatic queue_packet(input logic [3:0] flags, input logic [1:0] md, input logic sw,
			input int a, input int b, input int c);
		packet_q.push_back(make_packet(flags, md, sw, a, b, c));
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			if (mismatches < 10)
				$display("mismatch on %s, result %0d: expected %0d, got %0d",
					name, result_cnt, exp_v, act_v);
			mismatches++;
		end
	endtask

	task automatic write_reg(input logic [scfm_pkg::CFG_IDX_BITS-1:0] idx, input int data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= scfm_pkg::LIMIT_BITS'(data);
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			scfm_pkg::CFG_ABS_LIMIT:  cfg_abs = data & 32'h7FFF;
			scfm_pkg::CFG_RATE_LIMIT: cfg_rate = data & 32'h7FFF;
			scfm_pkg::CFG_PKT_LIMIT:  cfg_pkt_limit = data & 32'hFF;
			scfm_pkg::CFG_CHAN_LIMIT: cfg_chan_limit = data & 32'hFF;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_limits(input int abs_v, input int rate_v, input int pkt_v,
			input int chan_v);
		write_reg(scfm_pkg::CFG_ABS_LIMIT, abs_v);
		write_reg(scfm_pkg::CFG_RATE_LIMIT, rate_v);
		write_reg(scfm_pkg::CFG_PKT_LIMIT, pkt_v);
		write_reg(scfm_pkg::CFG_CHAN_LIMIT, chan_v);
	endtask

	task automatic drain();
		while (!(packet_q.size() == 0 && taken_cnt == offered_cnt && screened_q.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// driver: advance to the next item only once the current one is taken
	always @(negedge clk) begin
		if (arst_n && taken_cnt == offered_cnt) begin
			if (packet_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_pkt = packet_q.pop_front();
				in_valid <= 1'b1;
				timeout <= drv_pkt.timeout;
				header_ok <= drv_pkt.header_ok;
				checksum_ok <= drv_pkt.checksum_ok;
				payload_ok <= drv_pkt.payload_ok;
				mode <= drv_pkt.mode;
				switchover <= drv_pkt.switchover;
				sample_a <= drv_pkt.sample_a;
				sample_b <= drv_pkt.sample_b;
				sample_c <= drv_pkt.sample_c;
				offered_cnt++;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with a long hold on request
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
		end else if (hold_ack != hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_ack = hold_req;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (screened_q.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected result %0d with no item pending", result_cnt);
					mismatches++;
				end else begin
					want = screened_q.pop_front();
					check_field("value_a", want.va, value_a);
					check_field("value_b", want.vb, value_b);
					check_field("value_c", want.vc, value_c);
					check_field("limit_status", want.lstat, limit_status);
					check_field("fail_status", want.fstat, fail_status);
					check_field("packet_failed", want.pfail, packet_failed);
					check_field("substituted", want.subst, substituted);
				end
				result_cnt++;
			end
			if (in_valid && !in_stall) begin
				mon_pkt.timeout = timeout;
				mon_pkt.header_ok = header_ok;
				mon_pkt.checksum_ok = checksum_ok;
				mon_pkt.payload_ok = payload_ok;
				mon_pkt.mode = mode;
				mon_pkt.switchover = switchover;
				mon_pkt.sample_a = sample_a;
				mon_pkt.sample_b = sample_b;
				mon_pkt.sample_c = sample_c;
				screened_q.push_back(screen_packet(mon_pkt));
				taken_cnt++;
			end
		end
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed items at the reset limits
		queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 0, 0, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 2560, -2560, 200);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 2561, -2561, SAMPLE_MAX);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_44, 1'b0, SAMPLE_MAX, SAMPLE_MIN, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_44, 1'b1, 3000, 0, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_44, 1'b1, 100, 0, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_44, 1'b1, -3000, 0, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_44, 1'b0, -3000, 0, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_33, 1'b0, 3000, -3000, 2000);
		queue_packet(FLAG_PAYLOAD, scfm_pkg::MODE_33, 1'b1, -5000, 40, 2600);
		queue_packet(FLAG_TIMEOUT | FLAG_HEADER, scfm_pkg::MODE_OTHER, 1'b0,
			SAMPLE_MAX, SAMPLE_MIN, -1);
		queue_packet(FLAG_TIMEOUT, scfm_pkg::MODE_11, 1'b0, 10, 20, 30);
		queue_packet(FLAG_HEADER, scfm_pkg::MODE_11, 1'b0, -10, 5000, 30);
		queue_packet(FLAG_CHECKSUM, scfm_pkg::MODE_44, 1'b1, 4000, 20, -30);
		queue_packet(FLAG_PAYLOAD, scfm_pkg::MODE_44, 1'b0, 10, -20, 30);
		queue_packet(FLAG_ALL, scfm_pkg::MODE_11, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 201, -201, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_OTHER, 1'b0, -1, 1, 0);
		queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 400, -400, 199);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			case (phase)
				0: load_limits(SAMPLE_MAX, 0, scfm_pkg::COUNT_MAX, scfm_pkg::COUNT_MAX);
				1: load_limits(scfm_pkg::ABS_LIMIT_RST, scfm_pkg::RATE_LIMIT_RST,
					scfm_pkg::PKT_LIMIT_RST, scfm_pkg::CHAN_LIMIT_RST);
				2: load_limits($urandom_range(500, 8000), $urandom_range(1, 1500),
					$urandom_range(30, 80), $urandom_range(30, 80));
				3: load_limits(0, SAMPLE_MAX, scfm_pkg::COUNT_MAX, scfm_pkg::COUNT_MAX);
				4: load_limits($urandom_range(500, 8000), $urandom_range(1, 1500),
					$urandom_range(2, 12), $urandom_range(2, 12));
				5: load_limits($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX),
					1, 1);
				default: load_limits(1000, 500, scfm_pkg::COUNT_MAX, scfm_pkg::COUNT_MAX);
			endcase
			if (phase == SAT_PHASE) begin
				// drive both counters into saturation
				for (int n = 0; n < SAT_RUN; n++)
					queue_packet(4'($urandom_range(1, 15)), scfm_pkg::MODE_11, 1'b0,
						pick_sample(0), pick_sample(1), pick_sample(2));
				for (int n = 0; n < SAT_RUN; n++)
					queue_packet(FLAG_NONE, scfm_pkg::MODE_33, 1'b0,
						-1000 - int'($urandom_range(1, 9000)),
						1000 + int'($urandom_range(1, 9000)), SAMPLE_MIN);
				queue_packet(FLAG_NONE, scfm_pkg::MODE_11, 1'b0, 0, 0, 0);
			end else begin
				for (int n = 0; n < RUN_ITEMS; n++)
					packet_q.push_back(gen_packet());
			end
			// hold off the receiver while the sender keeps offering
			if (phase == 0 || phase == 4)
				hold_req++;
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && screened_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
